>>> sv/cpet_pkg.sv
// Shared types and constants for the contact pair event tracker.
package cpet_pkg;

    localparam int unsigned PORT_ID_BITS = 16;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_BEFORE = 2'd1;
    localparam logic [1:0] EV_DURING = 2'd2;
    localparam logic [1:0] EV_AFTER  = 2'd3;

    typedef struct packed {
        logic [PORT_ID_BITS-1:0] id_a;
        logic [PORT_ID_BITS-1:0] id_b;
        logic                    intersecting;
    } cpet_in_t;

    typedef struct packed {
        logic [1:0]              event_kind;
        logic [PORT_ID_BITS-1:0] low_id;
        logic [PORT_ID_BITS-1:0] high_id;
        logic                    table_overflow;
    } cpet_out_t;

    // Search token that walks down the row of slot cells.
    typedef struct packed {
        logic active;
        logic matched;
        logic freed;
    } cpet_scan_t;

    // Update broadcast to all cells once the search has finished.
    typedef struct packed {
        logic insert;
        logic remove;
    } cpet_commit_t;

endpackage

>>> sv/cpet_cell.sv
// One slot of the pair table, with its stage of the search chain.
module cpet_cell
    import cpet_pkg::*;
#(
    parameter int unsigned KEY_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cpet_scan_t          scan_in,
    input  logic [KEY_BITS-1:0] key,
    input  cpet_commit_t        commit,
    output cpet_scan_t          scan_out
);

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] pair_reg;
    logic [KEY_BITS-1:0] pair_next;
    logic                mark_match_reg;
    logic                mark_match_next;
    logic                mark_free_reg;
    logic                mark_free_next;
    cpet_scan_t          scan_reg;
    cpet_scan_t          scan_next;
    logic                hit;

    assign hit = valid_reg && (pair_reg == key);

    always_comb
    begin
        valid_next      = valid_reg;
        pair_next       = pair_reg;
        mark_match_next = mark_match_reg;
        mark_free_next  = mark_free_reg;
        scan_next       = scan_in;
        if (scan_in.active)
        begin
            // Only the first matching and the first free slot are marked.
            mark_match_next   = hit && !scan_in.matched;
            mark_free_next    = !valid_reg && !scan_in.freed;
            scan_next.matched = scan_in.matched || hit;
            scan_next.freed   = scan_in.freed || !valid_reg;
        end
        if (commit.insert && mark_free_reg)
        begin
            valid_next = 1'b1;
            pair_next  = key;
        end
        if (commit.remove && mark_match_reg)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            mark_match_reg <= 1'b0;
            mark_free_reg  <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            mark_match_reg <= mark_match_next;
            mark_free_reg  <= mark_free_next;
            scan_reg       <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign scan_out = scan_reg;

endmodule

>>> sv/contact_pair_event_tracker.sv
// Top level of the contact pair event tracker: control, item registers and the cell row.
//
// Usage. Each input transaction on in_data carries two object ids and a bit that
// says whether the objects overlap now. The block orders the ids, looks the pair
// up among the pairs that overlapped before and returns exactly one output
// transaction on out_data: none, before (pair newly stored), during (pair already
// stored) or after (pair removed). When a new pair finds every slot taken, the
// event is still before but table_overflow is set and the pair is not stored.
// Both channels use a valid/ready handshake. The table is a row of MAX_PAIRS
// cells; a search token steps one cell per clock, and the block takes no new
// item while that walk along the row and the commit of its result are under
// way. The output register frees the input side: the next item is accepted
// as soon as a result has been registered, even if the receiver has not yet
// taken it. If the receiver stalls, a finished search waits before updating the
// table until the output register is free. Reset clears every slot's valid mark
// at once, so the block accepts items in the first cycle after reset.
module contact_pair_event_tracker
    import cpet_pkg::*;
#(
    parameter int unsigned MAX_PAIRS = 64,
    parameter int unsigned ID_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cpet_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output cpet_out_t out_data
);

    localparam int unsigned KEY_BITS = 2 * ID_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [ID_BITS-1:0] lo_reg;
    logic [ID_BITS-1:0] lo_next;
    logic [ID_BITS-1:0] hi_reg;
    logic [ID_BITS-1:0] hi_next;
    logic               hit_reg;
    logic               hit_next;
    logic               matched_reg;
    logic               matched_next;
    logic               freed_reg;
    logic               freed_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    cpet_out_t          out_data_reg;
    cpet_out_t          out_data_next;

    logic [ID_BITS-1:0]  id_a_cut;
    logic [ID_BITS-1:0]  id_b_cut;
    logic [KEY_BITS-1:0] key;
    logic                in_accept;
    logic                out_free;
    cpet_commit_t        commit;
    cpet_scan_t          scan [MAX_PAIRS+1];

    // Ids are reduced to the configured width before ordering and matching.
    assign id_a_cut  = ID_BITS'(in_data.id_a);
    assign id_b_cut  = ID_BITS'(in_data.id_b);
    assign key       = {hi_reg, lo_reg};
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // The token enters the first cell during the start cycle, with no match and
    // no free slot seen so far.
    assign scan[0].active  = (state_reg == ST_START);
    assign scan[0].matched = 1'b0;
    assign scan[0].freed   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_PAIRS; g++)
        begin : g_cell
            cpet_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .scan_in  (scan[g]),
                .key      (key),
                .commit   (commit),
                .scan_out (scan[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        hit_next       = hit_reg;
        matched_next   = matched_reg;
        freed_next     = freed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        commit         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (id_a_cut < id_b_cut)
                    begin
                        lo_next = id_a_cut;
                        hi_next = id_b_cut;
                    end
                    else
                    begin
                        lo_next = id_b_cut;
                        hi_next = id_a_cut;
                    end
                    hit_next   = in_data.intersecting;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // The token has left the last cell: the whole table was seen.
                if (scan[MAX_PAIRS].active)
                begin
                    matched_next = scan[MAX_PAIRS].matched;
                    freed_next   = scan[MAX_PAIRS].freed;
                    state_next   = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    commit.insert = hit_reg && !matched_reg && freed_reg;
                    commit.remove = !hit_reg && matched_reg;
                    out_data_next.low_id         = PORT_ID_BITS'(lo_reg);
                    out_data_next.high_id        = PORT_ID_BITS'(hi_reg);
                    out_data_next.table_overflow = hit_reg && !matched_reg && !freed_reg;
                    if (hit_reg)
                    begin
                        out_data_next.event_kind = matched_reg ? EV_DURING : EV_BEFORE;
                    end
                    else
                    begin
                        out_data_next.event_kind = matched_reg ? EV_AFTER : EV_NONE;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        hit_reg      <= hit_next;
        matched_reg  <= matched_next;
        freed_reg    <= freed_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> tb/sv/cpet_tb_pkg.sv
// Pair table predictor and result checker for the contact pair event tracker bench.
`timescale 1ns / 100ps

package cpet_tb_pkg;

    import cpet_pkg::*;

    localparam int unsigned TRACKED_PAIRS = 64;
    localparam int unsigned PAIR_ID_BITS  = 16;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [PORT_ID_BITS-1:0] PAIR_ID_MASK =
        PORT_ID_BITS'((64'd1 << PAIR_ID_BITS) - 64'd1);

    class pair_event_predictor;

        logic [PORT_ID_BITS-1:0] stored_low  [TRACKED_PAIRS];
        logic [PORT_ID_BITS-1:0] stored_high [TRACKED_PAIRS];
        bit                      slot_used   [TRACKED_PAIRS];
        cpet_out_t               expected_events [$];
        int unsigned             mismatch_count;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i]   = 1'b0;
                stored_low[i]  = '0;
                stored_high[i] = '0;
            end
            mismatch_count = 0;
        endfunction

        // Works out the event for an accepted pair and updates the table copy.
        function void note_pair(cpet_in_t item);
            logic [PORT_ID_BITS-1:0] id_a;
            logic [PORT_ID_BITS-1:0] id_b;
            logic [PORT_ID_BITS-1:0] low;
            logic [PORT_ID_BITS-1:0] high;
            int                      match_slot;
            int                      free_slot;
            cpet_out_t               ev;

            id_a       = item.id_a & PAIR_ID_MASK;
            id_b       = item.id_b & PAIR_ID_MASK;
            low        = (id_a < id_b) ? id_a : id_b;
            high       = (id_a < id_b) ? id_b : id_a;
            match_slot = -1;
            free_slot  = -1;

            for (int i = 0; i < TRACKED_PAIRS; i++)
            begin
                if (slot_used[i])
                begin
                    if (match_slot < 0 && stored_low[i] == low && stored_high[i] == high)
                        match_slot = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end

            ev.event_kind     = EV_NONE;
            ev.low_id         = low;
            ev.high_id        = high;
            ev.table_overflow = 1'b0;

            if (item.intersecting)
            begin
                if (match_slot >= 0)
                begin
                    ev.event_kind = EV_DURING;
                end
                else
                begin
                    ev.event_kind = EV_BEFORE;
                    if (free_slot >= 0)
                    begin
                        stored_low[free_slot]  = low;
                        stored_high[free_slot] = high;
                        slot_used[free_slot]   = 1'b1;
                    end
                    else
                    begin
                        ev.table_overflow = 1'b1;
                    end
                end
            end
            else if (match_slot >= 0)
            begin
                ev.event_kind         = EV_AFTER;
                slot_used[match_slot] = 1'b0;
            end

            expected_events.insert(expected_events.size(), ev);
        endfunction

        // Compares a result transaction with the oldest expected event.
        function void check_event(cpet_out_t got);
            cpet_out_t want;

            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: kind=%0d low=%h high=%h ovf=%0b",
                             $time, got.event_kind, got.low_id, got.high_id,
                             got.table_overflow);
                return;
            end

            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind || got.low_id !== want.low_id ||
                got.high_id !== want.high_id ||
                got.table_overflow !== want.table_overflow)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"[%0t] mismatch: expected kind=%0d low=%h high=%h ovf=%0b,",
                              " got kind=%0d low=%h high=%h ovf=%0b"},
                             $time, want.event_kind, want.low_id, want.high_id,
                             want.table_overflow, got.event_kind, got.low_id,
                             got.high_id, got.table_overflow);
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

    endclass

endpackage

>>> tb/sv/tb_contact_pair_event_tracker.sv
// Self-checking bench for the contact pair event tracker.
`timescale 1ns / 100ps

module tb_contact_pair_event_tracker;

    import cpet_pkg::*;
    import cpet_tb_pkg::*;

    // The run limit allows for every transaction taking a whole table search inside
    // the block, with the longest sender gap and the longest receiver stall on top
    // of that, and then takes the total several times over.
    localparam int unsigned ITEM_CYCLES   = TRACKED_PAIRS + 3;
    localparam int unsigned LONG_IDLE_MAX = 120;
    localparam int unsigned RANDOM_ITEMS  = 1750;
    localparam int unsigned POOL_SIZE     = 96;
    localparam int unsigned DRAIN_CYCLES  = 2 * ITEM_CYCLES;
    localparam int unsigned RUN_LIMIT     = 2_000_000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    cpet_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    cpet_out_t out_data;

    // Shared by both sides: when clear, neither side inserts any idle cycles.
    bit idling_on;

    pair_event_predictor predictor;

    contact_pair_event_tracker #(
        .MAX_PAIRS (TRACKED_PAIRS),
        .ID_BITS   (PAIR_ID_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Most gaps are nil or short; roughly one in ten is long and can outlast a
    // whole table search, so that idling also falls on the cycles where the other
    // side is ready and waiting.
    function automatic int idle_gap();
        int r;

        if (!idling_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, LONG_IDLE_MAX);
    endfunction

    function automatic cpet_in_t make_pair(logic [15:0] a, logic [15:0] b, logic hit);
        cpet_in_t item;

        item.id_a         = a;
        item.id_b         = b;
        item.intersecting = hit;
        return item;
    endfunction

    // Offers one candidate pair and returns once the block has taken it. Inputs
    // only change at the falling edge; valid is dropped for a gap in one step and
    // raised again in a later one, never both in the same step.
    task automatic send_pair(input cpet_in_t item);
        int gap;

        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        predictor.note_pair(item);
    endtask

    // Reset and stimulus. The directed part walks one pair through every event,
    // with equal ids, both id orders and the extreme id values. The random part
    // then runs in rounds over a pool of pairs larger than the table: a round with
    // a high overlap rate fills the table until inserts overflow, and a round with
    // a low rate drains it again through after events. One transaction in ten is
    // noise with fully random ids.
    initial
    begin : stimulus
        logic [15:0] pool_a [POOL_SIZE];
        logic [15:0] pool_b [POOL_SIZE];
        cpet_in_t    item;
        int          sent;
        int          hit_pct;
        int          round_len;
        int          refresh;
        int          pick;
        bit          first_round;

        predictor = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        idling_on = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Equal ids at zero through before, during, after and none.
        send_pair(make_pair(16'h0000, 16'h0000, 1'b1));
        send_pair(make_pair(16'h0000, 16'h0000, 1'b1));
        send_pair(make_pair(16'h0000, 16'h0000, 1'b0));
        send_pair(make_pair(16'h0000, 16'h0000, 1'b0));
        // Extreme ids in both orders must be seen as the same pair.
        send_pair(make_pair(16'hFFFF, 16'h0000, 1'b1));
        send_pair(make_pair(16'h0000, 16'hFFFF, 1'b1));
        send_pair(make_pair(16'hFFFF, 16'h0000, 1'b0));
        send_pair(make_pair(16'hFFFF, 16'hFFFF, 1'b1));
        send_pair(make_pair(16'hFFFF, 16'hFFFF, 1'b1));
        send_pair(make_pair(16'hFFFF, 16'hFFFF, 1'b0));
        // A none event still reports the ids in order.
        send_pair(make_pair(16'h9000, 16'h0001, 1'b0));
        send_pair(make_pair(16'hAAAA, 16'h5555, 1'b1));
        send_pair(make_pair(16'h5555, 16'hAAAA, 1'b0));
        // Left stored so the random part starts with a slot taken.
        send_pair(make_pair(16'h8000, 16'h7FFF, 1'b1));

        sent        = 0;
        first_round = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            // The first round always uses a high overlap rate so that the table fills and overflow is reached.
            if (first_round)
                hit_pct = 95;
            else
                case ($urandom_range(0, 2))
                    0:       hit_pct = 5;
                    1:       hit_pct = 50;
                    default: hit_pct = 95;
                endcase
            idling_on = ($urandom_range(0, 3) != 0);
            round_len = $urandom_range(100, 220);

            // Fill the pool first, then renew part of it each round; about one pair in eight has equal ids.
            refresh = first_round ? POOL_SIZE : 8;
            for (int j = 0; j < refresh; j++)
            begin
                pick         = first_round ? j : $urandom_range(0, POOL_SIZE - 1);
                pool_a[pick] = 16'($urandom);
                pool_b[pick] = ($urandom_range(0, 7) == 0) ? pool_a[pick] : 16'($urandom);
            end
            first_round = 1'b0;

            for (int k = 0; k < round_len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    item = make_pair(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    if ($urandom_range(0, 1) == 0)
                        item = make_pair(pool_a[pick], pool_b[pick],
                                         ($urandom_range(0, 99) < hit_pct));
                    else
                        item = make_pair(pool_b[pick], pool_a[pick],
                                         ($urandom_range(0, 99) < hit_pct));
                end
                send_pair(item);
                sent++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Wait for every outstanding event, then a little longer so that any
        // spurious extra result transaction would still be caught.
        while (predictor.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predictor.mismatch_count == 0 && predictor.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: ready is driven at the falling edge and held low for a random
    // stall after each accepted transaction; results are taken at the rising edge.
    initial
    begin : result_side
        int stall;

        out_ready = 1'b0;
        stall     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                predictor.check_event(out_data);
                stall = idle_gap();
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        int unsigned cycles;

        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= RUN_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
sv/cpet_pkg.sv
sv/cpet_cell.sv
sv/contact_pair_event_tracker.sv
tb/sv/cpet_tb_pkg.sv
tb/sv/tb_contact_pair_event_tracker.sv
